// File: hw/rtl/iterated_sphere_inversion_distance_defines.svh
// Assertion macros for the sphere inversion distance estimator.
// Used by the checker module only; no other dependencies.
`ifndef ITERATED_SPHERE_INVERSION_DISTANCE_DEFINES_SVH
`define ITERATED_SPHERE_INVERSION_DISTANCE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is active.
`define ISID_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define ISID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/isid_pkg.sv
// Shared types and constants of the sphere inversion distance estimator.
// No dependencies; imported by every module of the block.
package isid_pkg;

  // Fraction bits of the Q12.20 coordinate format.
  localparam int unsigned FRAC_BITS = 20;

  // Configuration port data width (widest register).
  localparam int unsigned CFG_W = 16;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_LOAD_INV = 2'd0;
  localparam logic [1:0] OP_LOAD_CVX = 2'd1;
  localparam logic [1:0] OP_EVAL     = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_INV_COUNT = 2'd0;
  localparam logic [1:0] CFG_CVX_COUNT = 2'd1;
  localparam logic [1:0] CFG_MAX_ITER  = 2'd2;

  localparam logic [15:0] MAX_ITER_RESET = 16'd10000;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    AR_MUL,
    AR_DIV,
    AR_SQRT
  } arith_op_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         slot;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [30:0]        radius;
  } in_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic               limit_reached;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        r;
  } sphere_t;

  typedef struct packed {
    logic         start;
    arith_op_e    op;
    logic [127:0] a;
    logic [63:0]  b;
  } arith_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] res;
  } arith_rsp_t;

endpackage

// File: hw/rtl/isid_arith.sv
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide
// and digit-by-digit square root. Depends on isid_pkg.
module isid_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isid_pkg::arith_req_t req_i,
  output isid_pkg::arith_rsp_t rsp_o
);
  import isid_pkg::*;

  arith_op_e    op_q;
  logic         busy_q;
  logic         done_q;
  logic [6:0]   cnt_q;
  logic [127:0] w_q;
  logic [127:0] acc_q;
  logic [63:0]  x_q;
  logic [67:0]  r_q;

  logic [64:0]  drs;
  logic         dge;
  logic [67:0]  srs;
  logic [67:0]  strial;
  logic         sge;

  // Trial subtractions of one divide step and one square root step.
  always_comb begin
    drs    = {r_q[63:0], w_q[127]};
    dge    = drs >= {1'b0, x_q};
    srs    = {r_q[65:0], w_q[127:126]};
    strial = {2'b00, x_q, 2'b01};
    sge    = srs >= strial;
  end

  // One step per cycle; done pulses once the registers hold the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= AR_MUL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      w_q    <= '0;
      acc_q  <= '0;
      x_q    <= '0;
      r_q    <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == 7'd0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        r_q    <= '0;
        acc_q  <= '0;
        unique case (req_i.op)
          AR_MUL: begin
            w_q   <= 128'(req_i.a[63:0]);
            x_q   <= req_i.b;
            cnt_q <= 7'd63;
          end
          AR_DIV: begin
            w_q   <= req_i.a;
            x_q   <= req_i.b;
            cnt_q <= 7'd127;
          end
          AR_SQRT: begin
            w_q   <= req_i.a;
            x_q   <= '0;
            cnt_q <= 7'd63;
          end
          default: begin
            w_q   <= req_i.a;
            x_q   <= req_i.b;
            cnt_q <= 7'd63;
          end
        endcase
      end else if (busy_q) begin
        case (op_q)
          AR_MUL: begin
            if (x_q[0]) begin
              acc_q <= acc_q + w_q;
            end
            w_q <= w_q << 1;
            x_q <= x_q >> 1;
          end
          AR_DIV: begin
            r_q <= 68'(dge ? drs - {1'b0, x_q} : drs);
            w_q <= {w_q[126:0], dge};
          end
          AR_SQRT: begin
            r_q <= sge ? srs - strial : srs;
            x_q <= {x_q[62:0], sge};
            w_q <= w_q << 2;
          end
          default: ;
        endcase
        if (cnt_q == 7'd0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 7'd1;
        end
      end
    end
  end

  // Result selection by the operation last run.
  always_comb begin
    rsp_o.done = done_q;
    case (op_q)
      AR_MUL:  rsp_o.res = acc_q;
      AR_DIV:  rsp_o.res = w_q;
      default: rsp_o.res = 128'(x_q);
    endcase
  end

endmodule

// File: hw/rtl/isid_table.sv
// Sphere table memory: inverting spheres in the lower half, convex bounding
// spheres in the upper half. One write and one registered read port. Uses isid_pkg.
module isid_table #(
  parameter int unsigned AW = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  isid_pkg::sphere_t wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output isid_pkg::sphere_t rdata_o
);
  import isid_pkg::*;

  localparam int unsigned DEPTH = 2 ** AW;

  sphere_t mem_q [DEPTH];
  sphere_t rdata_q;

  // Entries hold no reset value; the user must load them before they are read, the block does not enforce it.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/iterated_sphere_inversion_distance.sv
// Iterated sphere inversion distance estimator. A load transaction writes one entry of
// the inverting or convex sphere table. An evaluate transaction runs passes over the
// inverting spheres, inverting the point through every sphere that contains it, until
// a pass inverts nothing or max_iterations passes are done, then takes the best signed
// distance over all spheres and divides it by the accumulated scale. All arithmetic goes
// through one bit-serial unit, used in turn by each sphere test, each inversion, each
// sphere of the final estimate and the final quotient. The block takes no input while
// it evaluates; a finished result waits in an output register, and load transactions
// are taken meanwhile.
module iterated_sphere_inversion_distance #(
  parameter int unsigned MAX_SPHERES = 16,
  parameter int unsigned COORD_BITS  = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [isid_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  isid_pkg::in_t            in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output isid_pkg::out_t           out_data_o
);
  import isid_pkg::*;

  localparam int unsigned IDXW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int unsigned CNTW = $clog2(MAX_SPHERES + 1);
  localparam int unsigned DW   = ((COORD_BITS > 32) ? COORD_BITS : 32) + 1;
  localparam int unsigned LSW  = 2 * DW + 2;
  localparam int unsigned BW   = DW + 3;
  localparam logic signed [63:0] CHI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] CLO = -CHI - 64'sd1;
  localparam logic signed [BW-1:0] BEST_INIT = -(BW'(64'sd1 <<< FRAC_BITS));

  typedef enum logic [4:0] {
    S_IDLE, S_PASS, S_NEXT, S_RD, S_DMUL, S_R2, S_TEST, S_QMUL, S_QDIV,
    S_SMUL, S_SDIV, S_EST, S_ENEXT, S_SQRT, S_FDIV, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_INVERT,
    PH_EST_CVX,
    PH_EST_INV
  } phase_e;

  state_e                        state_q;
  phase_e                        phase_q;
  logic [4:0]                    inv_cnt_q;
  logic [4:0]                    cvx_cnt_q;
  logic [15:0]                   max_it_q;
  logic signed [COORD_BITS-1:0]  p_q [3];
  logic [63:0]                   scale_q;
  logic [LSW-1:0]                ls_q;
  logic [61:0]                   r2_q;
  logic [127:0]                  t_q;
  logic [1:0]                    axis_q;
  logic [CNTW-1:0]               idx_q;
  logic [15:0]                   pass_q;
  logic                          acted_q;
  logic                          last_q;
  logic                          sat_q;
  logic                          issued_q;
  logic signed [BW-1:0]          best_q;
  out_t                          fin_q;
  out_t                          out_q;
  logic                          out_valid_q;

  logic                          in_acc;
  logic [CNTW-1:0]               ni;
  logic [CNTW-1:0]               nc;
  logic                          tbl_we;
  logic [IDXW:0]                 tbl_waddr;
  sphere_t                       tbl_wdata;
  logic                          tbl_re;
  logic [IDXW:0]                 tbl_raddr;
  sphere_t                       tbl_rdata;
  arith_req_t                    arith_req;
  arith_rsp_t                    arith_rsp;

  logic signed [COORD_BITS-1:0]  p_ax;
  logic signed [31:0]            c_ax;
  logic signed [DW-1:0]          d_ax;
  logic [DW-1:0]                 dmag;
  logic                          q_big;
  logic signed [63:0]            m64;
  logic signed [63:0]            c64;
  logic signed [63:0]            v64;
  logic [BW-1:0]                 len_x;
  logic [BW-1:0]                 rad_x;
  logic signed [BW-1:0]          cand;
  logic                          bneg;
  logic [BW-1:0]                 bmag;
  logic [63:0]                   lim;
  logic [63:0]                   mq;
  out_t                          fin_d;

  function automatic logic signed [COORD_BITS-1:0] clamp_c(input logic signed [63:0] v);
    if (v > CHI) begin
      return CHI[COORD_BITS-1:0];
    end else if (v < CLO) begin
      return CLO[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic ovf_c(input logic signed [63:0] v);
    return (v > CHI) || (v < CLO);
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sphere counts clamped to the table depth.
  always_comb begin
    ni = (32'(inv_cnt_q) > MAX_SPHERES) ? CNTW'(MAX_SPHERES) : CNTW'(inv_cnt_q);
    nc = (32'(cvx_cnt_q) > MAX_SPHERES) ? CNTW'(MAX_SPHERES) : CNTW'(cvx_cnt_q);
  end

  // Table write from load transactions, read from the sequencer.
  always_comb begin
    tbl_we = in_acc && ((in_data_i.op == OP_LOAD_INV) || (in_data_i.op == OP_LOAD_CVX))
             && (32'(in_data_i.slot) < MAX_SPHERES);
    tbl_waddr   = {in_data_i.op == OP_LOAD_CVX, IDXW'(in_data_i.slot)};
    tbl_wdata.x = in_data_i.point_x;
    tbl_wdata.y = in_data_i.point_y;
    tbl_wdata.z = in_data_i.point_z;
    tbl_wdata.r = in_data_i.radius;
    tbl_re      = (state_q == S_RD);
    tbl_raddr   = {phase_q == PH_EST_CVX, idx_q[IDXW-1:0]};
  end

  isid_table #(
    .AW(IDXW + 1)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Offset of the point from the current sphere along the current axis.
  always_comb begin
    case (axis_q)
      2'd0: begin
        p_ax = p_q[0];
        c_ax = tbl_rdata.x;
      end
      2'd1: begin
        p_ax = p_q[1];
        c_ax = tbl_rdata.y;
      end
      default: begin
        p_ax = p_q[2];
        c_ax = tbl_rdata.z;
      end
    endcase
    d_ax = DW'(p_ax) - DW'(c_ax);
    dmag = d_ax[DW-1] ? DW'(-d_ax) : DW'(d_ax);
  end

  // New coordinate after inversion: offset capped at 2^62, then clamped.
  always_comb begin
    q_big = (|arith_rsp.res[127:63]) || (arith_rsp.res[62] && (|arith_rsp.res[61:0]));
    m64   = q_big ? 64'sh4000_0000_0000_0000 : arith_rsp.res[63:0];
    c64   = 64'(c_ax);
    v64   = d_ax[DW-1] ? c64 - m64 : c64 + m64;
  end

  // Distance candidate of the current sphere and the final quotient.
  always_comb begin
    len_x = BW'(arith_rsp.res[DW:0]);
    rad_x = BW'(tbl_rdata.r);
    cand  = (phase_q == PH_EST_CVX) ? $signed(len_x - rad_x) : $signed(rad_x - len_x);
    bneg  = best_q[BW-1];
    bmag  = bneg ? BW'(-best_q) : BW'(best_q);
    lim   = bneg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
    mq    = ((|arith_rsp.res[127:64]) || (arith_rsp.res[63:0] > lim))
            ? lim : arith_rsp.res[63:0];
    fin_d.distance      = bneg ? -mq[31:0] : mq[31:0];
    fin_d.limit_reached = last_q;
    fin_d.saturated     = sat_q || (|arith_rsp.res[127:64]) || (arith_rsp.res[63:0] > lim);
  end

  // Request to the shared unit, issued whenever an arithmetic state has no operation outstanding.
  always_comb begin
    arith_req.start = 1'b0;
    arith_req.op    = AR_MUL;
    arith_req.a     = 128'(dmag);
    arith_req.b     = 64'(dmag);
    unique case (state_q)
      S_DMUL: begin
        arith_req.start = !issued_q;
      end
      S_R2: begin
        arith_req.start = !issued_q;
        arith_req.a     = 128'(tbl_rdata.r);
        arith_req.b     = 64'(tbl_rdata.r);
      end
      S_QMUL: begin
        arith_req.start = !issued_q;
        arith_req.b     = 64'(r2_q);
      end
      S_QDIV, S_SDIV: begin
        arith_req.start = !issued_q;
        arith_req.op    = AR_DIV;
        arith_req.a     = t_q;
        arith_req.b     = ls_q[63:0];
      end
      S_SMUL: begin
        arith_req.start = !issued_q;
        arith_req.a     = 128'(scale_q);
        arith_req.b     = 64'(r2_q);
      end
      S_SQRT: begin
        arith_req.start = !issued_q;
        arith_req.op    = AR_SQRT;
        arith_req.a     = 128'(ls_q);
        arith_req.b     = '0;
      end
      S_FDIV: begin
        arith_req.start = !issued_q;
        arith_req.op    = AR_DIV;
        arith_req.a     = 128'({bmag, 32'h0000_0000});
        arith_req.b     = scale_q;
      end
      default: ;
    endcase
  end

  isid_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .rsp_o  (arith_rsp)
  );

  // Sequencer: configuration, inversion passes, distance estimate, output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_INVERT;
      inv_cnt_q   <= '0;
      cvx_cnt_q   <= '0;
      max_it_q    <= MAX_ITER_RESET;
      p_q         <= '{default: '0};
      scale_q     <= '0;
      ls_q        <= '0;
      r2_q        <= '0;
      t_q         <= '0;
      axis_q      <= '0;
      idx_q       <= '0;
      pass_q      <= '0;
      acted_q     <= 1'b0;
      last_q      <= 1'b0;
      sat_q       <= 1'b0;
      issued_q    <= 1'b0;
      best_q      <= '0;
      fin_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_INV_COUNT: inv_cnt_q <= cfg_data_i[4:0];
          CFG_CVX_COUNT: cvx_cnt_q <= cfg_data_i[4:0];
          CFG_MAX_ITER:  max_it_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      // A taken result clears the output unless a new one replaces it.
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      if (arith_req.start) begin
        issued_q <= 1'b1;
      end
      if (arith_rsp.done) begin
        issued_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (in_data_i.op == OP_EVAL)) begin
            p_q[0]  <= clamp_c(64'(in_data_i.point_x));
            p_q[1]  <= clamp_c(64'(in_data_i.point_y));
            p_q[2]  <= clamp_c(64'(in_data_i.point_z));
            sat_q   <= ovf_c(64'(in_data_i.point_x)) || ovf_c(64'(in_data_i.point_y))
                       || ovf_c(64'(in_data_i.point_z));
            scale_q <= 64'h0000_0001_0000_0000;
            pass_q  <= '0;
            last_q  <= 1'b0;
            state_q <= S_PASS;
          end
        end

        S_PASS: begin
          if (pass_q == max_it_q) begin
            state_q <= S_EST;
          end else begin
            acted_q <= 1'b0;
            idx_q   <= '0;
            phase_q <= PH_INVERT;
            state_q <= S_NEXT;
          end
        end

        S_NEXT: begin
          if (idx_q == ni) begin
            last_q  <= acted_q;
            pass_q  <= pass_q + 16'd1;
            state_q <= acted_q ? S_PASS : S_EST;
          end else begin
            state_q <= S_RD;
          end
        end

        S_RD: begin
          ls_q    <= '0;
          axis_q  <= '0;
          state_q <= S_DMUL;
        end

        // Squared distance, one axis at a time.
        S_DMUL: begin
          if (arith_rsp.done) begin
            ls_q <= ls_q + arith_rsp.res[LSW-1:0];
            if (axis_q == 2'd2) begin
              axis_q  <= '0;
              state_q <= (phase_q == PH_INVERT) ? S_R2 : S_SQRT;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end
        end

        S_R2: begin
          if (arith_rsp.done) begin
            r2_q    <= arith_rsp.res[61:0];
            state_q <= S_TEST;
          end
        end

        // Strictly inside test; a point on the centre saturates the scale.
        S_TEST: begin
          if (!(ls_q < LSW'(r2_q))) begin
            idx_q   <= idx_q + CNTW'(1);
            state_q <= S_NEXT;
          end else if (ls_q == '0) begin
            scale_q <= '1;
            sat_q   <= 1'b1;
            acted_q <= 1'b1;
            idx_q   <= idx_q + CNTW'(1);
            state_q <= S_NEXT;
          end else begin
            axis_q  <= '0;
            state_q <= S_QMUL;
          end
        end

        S_QMUL: begin
          if (arith_rsp.done) begin
            t_q     <= arith_rsp.res;
            state_q <= S_QDIV;
          end
        end

        S_QDIV: begin
          if (arith_rsp.done) begin
            p_q[axis_q] <= clamp_c(v64);
            if (q_big || ovf_c(v64)) begin
              sat_q <= 1'b1;
            end
            if (axis_q == 2'd2) begin
              axis_q  <= '0;
              state_q <= S_SMUL;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= S_QMUL;
            end
          end
        end

        S_SMUL: begin
          if (arith_rsp.done) begin
            t_q     <= arith_rsp.res;
            state_q <= S_SDIV;
          end
        end

        S_SDIV: begin
          if (arith_rsp.done) begin
            if (|arith_rsp.res[127:64]) begin
              scale_q <= '1;
              sat_q   <= 1'b1;
            end else begin
              scale_q <= arith_rsp.res[63:0];
            end
            acted_q <= 1'b1;
            idx_q   <= idx_q + CNTW'(1);
            state_q <= S_NEXT;
          end
        end

        S_EST: begin
          best_q  <= BEST_INIT;
          phase_q <= PH_EST_CVX;
          idx_q   <= '0;
          state_q <= S_ENEXT;
        end

        // Convex spheres first, then the inverting spheres.
        S_ENEXT: begin
          if (phase_q == PH_EST_CVX) begin
            if (idx_q == nc) begin
              phase_q <= PH_EST_INV;
              idx_q   <= '0;
            end else begin
              state_q <= S_RD;
            end
          end else if (idx_q == ni) begin
            state_q <= S_FDIV;
          end else begin
            state_q <= S_RD;
          end
        end

        S_SQRT: begin
          if (arith_rsp.done) begin
            if (cand > best_q) begin
              best_q <= cand;
            end
            idx_q   <= idx_q + CNTW'(1);
            state_q <= S_ENEXT;
          end
        end

        S_FDIV: begin
          if (arith_rsp.done) begin
            fin_q   <= fin_d;
            state_q <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= fin_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/isid_checker.sv
// Port-level checks of the sphere inversion distance estimator, bound to the top level.
// Depends on isid_pkg and the assertion macro header.
`include "iterated_sphere_inversion_distance_defines.svh"

module isid_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input isid_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input isid_pkg::out_t out_data_o
);
  import isid_pkg::*;

  // A waiting result stays offered and unchanged.
  `ISID_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")

  // An evaluate transaction makes the block busy in the next cycle.
  `ISID_ASSERT(a_eval_busy, clk_i, rst_ni, in_valid_i && in_ready_o && in_data_i.op == OP_EVAL |=> !in_ready_o, "input taken during evaluation")

  // Any other transaction leaves the block ready in the next cycle.
  `ISID_ASSERT(a_load_fast, clk_i, rst_ni, in_valid_i && in_ready_o && in_data_i.op != OP_EVAL |=> in_ready_o, "load did not complete in one cycle")

  // No result is offered while reset is active.
  `ISID_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "result offered during reset")

endmodule

bind iterated_sphere_inversion_distance isid_checker u_isid_checker (.*);
